>>> sv/pilot_frequency_phase_lock_loop_assert.svh
// assertion macros shared by the loop's checker
`ifndef PILOT_FREQUENCY_PHASE_LOCK_LOOP_ASSERT_SVH
`define PILOT_FREQUENCY_PHASE_LOCK_LOOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define PFPLL_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error("pfpll: check failed");

// consequent must hold in the cycle after the antecedent
`define PFPLL_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error("pfpll: check failed");

`endif

>>> sv/pfpll_pkg.sv
// shared types, constants and the arctangent table of the pilot loop
package pfpll_pkg;

  localparam int SAMPLE_WIDTH_DEF     = 16;
  localparam int PHASE_WIDTH_DEF      = 32;
  localparam int ANGLE_ITERATIONS_DEF = 16;

  localparam int ATAN_ENTRIES = 24;
  localparam int ITER_W       = 5;
  localparam int CW           = 34;  // cordic x/y, room for the vectoring gain
  localparam int ZW           = 32;  // angle, 2^32 per turn
  localparam int MUL_AW       = 33;
  localparam int MUL_BW       = 32;
  localparam int MUL_PW       = MUL_AW + MUL_BW;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 32;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_GAIN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_GAIN    = 2'd3;

  localparam logic [15:0] FILTER_COEFF_RST = 16'd1206;
  localparam logic [31:0] START_FREQ_RST   = 32'hBFFD53B8;
  localparam logic [31:0] PHASE_GAIN_RST   = 32'd42949673;
  localparam logic [31:0] FREQ_GAIN_RST    = 32'd107374;

  localparam logic signed [CW-1:0] CORDIC_START = 34'sd652032874;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd1073741824;

  typedef struct packed {
    logic              load;
    logic              step;
    logic              vec;
    logic [ITER_W-1:0] k;
  } cordic_ctrl_t;

  function automatic logic [ZW-1:0] atan_entry(input logic [ITER_W-1:0] k);
    case (k)
      5'd0:    atan_entry = 32'h20000000;
      5'd1:    atan_entry = 32'h12E4051E;
      5'd2:    atan_entry = 32'h09FB385B;
      5'd3:    atan_entry = 32'h051111D4;
      5'd4:    atan_entry = 32'h028B0D43;
      5'd5:    atan_entry = 32'h0145D7E1;
      5'd6:    atan_entry = 32'h00A2F61E;
      5'd7:    atan_entry = 32'h00517C55;
      5'd8:    atan_entry = 32'h0028BE53;
      5'd9:    atan_entry = 32'h00145F2F;
      5'd10:   atan_entry = 32'h000A2F98;
      5'd11:   atan_entry = 32'h000517CC;
      5'd12:   atan_entry = 32'h00028BE6;
      5'd13:   atan_entry = 32'h000145F3;
      5'd14:   atan_entry = 32'h0000A2FA;
      5'd15:   atan_entry = 32'h0000517D;
      5'd16:   atan_entry = 32'h000028BE;
      5'd17:   atan_entry = 32'h0000145F;
      5'd18:   atan_entry = 32'h00000A30;
      5'd19:   atan_entry = 32'h00000518;
      5'd20:   atan_entry = 32'h0000028C;
      5'd21:   atan_entry = 32'h00000146;
      5'd22:   atan_entry = 32'h000000A3;
      5'd23:   atan_entry = 32'h00000051;
      default: atan_entry = 32'h00000000;
    endcase
  endfunction

endpackage

>>> sv/pfpll_cordic.sv
// shared cordic stage: one rotation or vectoring micro-rotation per cycle while step is set and load is not
module pfpll_cordic (
  input  logic                              clk,
  input  pfpll_pkg::cordic_ctrl_t           ctrl,
  input  logic signed [pfpll_pkg::CW-1:0]   x0,
  input  logic signed [pfpll_pkg::CW-1:0]   y0,
  input  logic signed [pfpll_pkg::ZW-1:0]   z0,
  output logic signed [pfpll_pkg::CW-1:0]   x_r,
  output logic signed [pfpll_pkg::CW-1:0]   y_r,
  output logic signed [pfpll_pkg::ZW-1:0]   z_r
);
  import pfpll_pkg::*;

  logic signed [CW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [ZW-1:0] at, z_nxt;
  logic                 ccw;

  always_comb begin
    dx  = y_r >>> ctrl.k;
    dy  = x_r >>> ctrl.k;
    at  = signed'(atan_entry(ctrl.k));
    // rotation drives z to zero, vectoring drives y to zero
    ccw = ctrl.vec ? !(y_r > 0) : (z_r >= 0);
    if (ccw) begin
      x_nxt = x_r - dx;
      y_nxt = y_r + dy;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + dx;
      y_nxt = y_r - dy;
      z_nxt = z_r + at;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (ctrl.step) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

endmodule

>>> sv/pfpll_mul.sv
// shared signed multiplier with registered product
module pfpll_mul (
  input  logic                                clk,
  input  logic signed [pfpll_pkg::MUL_AW-1:0] a,
  input  logic signed [pfpll_pkg::MUL_BW-1:0] b,
  output logic signed [pfpll_pkg::MUL_PW-1:0] p_r
);
  import pfpll_pkg::*;

  logic signed [MUL_PW-1:0] p_nxt;

  assign p_nxt = MUL_PW'(a) * MUL_PW'(b);

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

>>> sv/pilot_frequency_phase_lock_loop.sv
// Pilot frequency/phase locked loop. Each accepted complex sample advances the
// oscillator, is mixed with its sin/cos and yields one real output sample; the
// mixed vector is low-pass filtered and its clamped angle corrects phase and
// frequency. An item keeps the block busy from its transfer until ready comes
// back, and no new sample is taken before then; the angle pass of the cordic
// is skipped when the filtered vector is zero or points left. The busy time
// is set by the single cordic stage, used for sin/cos and again for the angle
// (min(ANGLE_ITERATIONS, 24) micro-rotations per pass), and by the single
// multiplier, used for the four mixer products, the two filter updates and the
// two loop gains. A result waits in an output register; the next item's result
// stalls only if that register is still full. Configuration writes are taken
// at any cycle and belong between items; writing start_freq reloads the
// increment and clears the phase.
module pilot_frequency_phase_lock_loop #(
  parameter int SAMPLE_WIDTH     = pfpll_pkg::SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH      = pfpll_pkg::PHASE_WIDTH_DEF,
  parameter int ANGLE_ITERATIONS = pfpll_pkg::ANGLE_ITERATIONS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_i,
  input  logic signed [SAMPLE_WIDTH-1:0]       in_sample_q,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [SAMPLE_WIDTH-1:0]       out_mixed_real,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pfpll_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pfpll_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import pfpll_pkg::*;

  localparam int N_ITER = (ANGLE_ITERATIONS < ATAN_ENTRIES) ? ANGLE_ITERATIONS : ATAN_ENTRIES;
  localparam logic [ITER_W-1:0] K_LAST = ITER_W'(N_ITER - 1);
  localparam logic [31:0] KEEP = ~((32'd1 << (32 - PHASE_WIDTH)) - 32'd1);
  localparam int SC_W  = 17;                     // sin/cos after quadrant negation
  localparam int RE_W  = SAMPLE_WIDTH + SC_W + 1; // mixer sum
  localparam int OUT_W = RE_W - 15;
  localparam int LPI_W = RE_W - (SAMPLE_WIDTH - 8);
  localparam int LP_W  = 24;
  localparam int RQ_W  = CW - 15;
  localparam logic signed [OUT_W-1:0] OUT_MAX = OUT_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [OUT_W-1:0] OUT_MIN = -OUT_MAX - OUT_W'(1);

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;

  localparam logic [ITER_W-1:0] STEP0 = ITER_W'(0);
  localparam logic [ITER_W-1:0] STEP1 = ITER_W'(1);
  localparam logic [ITER_W-1:0] STEP2 = ITER_W'(2);
  localparam logic [ITER_W-1:0] STEP3 = ITER_W'(3);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SETUP  = 11'b00000000010,
    S_ROT    = 11'b00000000100,
    S_SINCOS = 11'b00000001000,
    S_MIX    = 11'b00000010000,
    S_OUT    = 11'b00000100000,
    S_LPF    = 11'b00001000000,
    S_VSETUP = 11'b00010000000,
    S_VEC    = 11'b00100000000,
    S_ERR    = 11'b01000000000,
    S_CORR   = 11'b10000000000
  } state_t;

  function automatic logic signed [SC_W-1:0] round_q15(input logic signed [CW-1:0] v);
    logic signed [CW-1:0]   t;
    logic signed [RQ_W-1:0] s;
    t = v + CW'(16384);
    s = t[CW-1:15];
    if (s > RQ_W'(32767)) begin
      round_q15 = SC_W'(32767);
    end else if (s < RQ_W'(-32768)) begin
      round_q15 = SC_W'(-32768);
    end else begin
      round_q15 = SC_W'(s);
    end
  endfunction

  function automatic logic signed [LP_W-1:0] sat_lp(input logic signed [LP_W+2:0] v);
    if (v > (LP_W+3)'(8388607)) begin
      sat_lp = LP_W'(8388607);
    end else if (v < (LP_W+3)'(-8388608)) begin
      sat_lp = LP_W'(-8388608);
    end else begin
      sat_lp = LP_W'(v);
    end
  endfunction

  state_t                   state_r, state_nxt;
  logic [ITER_W-1:0]        cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [31:0]              phase_r, phase_nxt;
  logic [31:0]              inc_r, inc_nxt;
  logic [15:0]              coeff_r, coeff_nxt;
  logic [31:0]              pg_r, pg_nxt;
  logic [31:0]              fg_r, fg_nxt;
  logic signed [LP_W-1:0]   lpr_r, lpr_nxt;
  logic signed [LP_W-1:0]   lpi_r, lpi_nxt;

  logic signed [SAMPLE_WIDTH-1:0] si_r, si_nxt, sq_r, sq_nxt;
  logic signed [SAMPLE_WIDTH-1:0] out_data_r, out_data_nxt;
  logic [1:0]               quad_r, quad_nxt;
  logic signed [SC_W-1:0]   sn_r, sn_nxt, cs_r, cs_nxt;
  logic signed [RE_W-1:0]   re_r, re_nxt, im_r, im_nxt;
  logic signed [LP_W-1:0]   xr_r, xr_nxt, xi_r, xi_nxt;
  logic signed [LP_W:0]     dr_r, dr_nxt, di_r, di_nxt;
  logic signed [25:0]       lpstep_r, lpstep_nxt;
  logic signed [ZW-1:0]     err_r, err_nxt;
  logic [31:0]              corr_r, corr_nxt;

  cordic_ctrl_t             cor_ctrl;
  logic signed [CW-1:0]     cor_x0, cor_y0, cor_x, cor_y;
  logic signed [ZW-1:0]     cor_z0, cor_z;
  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] mul_p;

  logic signed [SC_W-1:0]         xs, ys;
  logic signed [RE_W-1:0]         p_mix, out_t;
  logic signed [OUT_W-1:0]        out_sh;
  logic signed [SAMPLE_WIDTH-1:0] out_val;
  logic signed [LPI_W-1:0]        rs_re, rs_im;
  logic signed [41:0]             lp_sum;
  logic signed [MUL_PW-1:0]       c_sum;
  logic signed [ZW-1:0]           z_clamp;

  pfpll_cordic u_cordic (
    .clk  (clk),
    .ctrl (cor_ctrl),
    .x0   (cor_x0),
    .y0   (cor_y0),
    .z0   (cor_z0),
    .x_r  (cor_x),
    .y_r  (cor_y),
    .z_r  (cor_z)
  );

  pfpll_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign xs     = round_q15(cor_x);
  assign ys     = round_q15(cor_y);
  assign p_mix  = mul_p[RE_W-1:0];
  assign out_t  = re_r + RE_W'(16384);
  assign out_sh = out_t[RE_W-1:15];
  assign rs_re  = LPI_W'(re_r >>> (SAMPLE_WIDTH - 8));
  assign rs_im  = LPI_W'(im_r >>> (SAMPLE_WIDTH - 8));
  assign lp_sum = mul_p[41:0] + 42'sd32768;
  assign c_sum  = mul_p + MUL_PW'(64'sd2147483648);

  always_comb begin
    if (out_sh > OUT_MAX) begin
      out_val = SAMPLE_WIDTH'(OUT_MAX);
    end else if (out_sh < OUT_MIN) begin
      out_val = SAMPLE_WIDTH'(OUT_MIN);
    end else begin
      out_val = SAMPLE_WIDTH'(out_sh);
    end
  end

  always_comb begin
    if (cor_z > QUARTER_TURN) begin
      z_clamp = QUARTER_TURN;
    end else if (cor_z < -QUARTER_TURN) begin
      z_clamp = -QUARTER_TURN;
    end else begin
      z_clamp = cor_z;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    inc_nxt       = inc_r;
    coeff_nxt     = coeff_r;
    pg_nxt        = pg_r;
    fg_nxt        = fg_r;
    lpr_nxt       = lpr_r;
    lpi_nxt       = lpi_r;
    si_nxt        = si_r;
    sq_nxt        = sq_r;
    out_data_nxt  = out_data_r;
    quad_nxt      = quad_r;
    sn_nxt        = sn_r;
    cs_nxt        = cs_r;
    re_nxt        = re_r;
    im_nxt        = im_r;
    xr_nxt        = xr_r;
    xi_nxt        = xi_r;
    dr_nxt        = dr_r;
    di_nxt        = di_r;
    lpstep_nxt    = lpstep_r;
    err_nxt       = err_r;
    corr_nxt      = corr_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cor_ctrl      = '{load: 1'b0, step: 1'b0, vec: 1'b0, k: cnt_r};
    cor_x0        = CORDIC_START;
    cor_y0        = '0;
    cor_z0        = ZW'(signed'(phase_r[29:0]));
    mul_a         = '0;
    mul_b         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          phase_nxt = (phase_r + inc_r) & KEEP;
          si_nxt    = in_sample_i;
          sq_nxt    = in_sample_q;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        // residual angle is the low 30 bits taken as signed, quadrant rounds up
        cor_ctrl.load = 1'b1;
        quad_nxt      = phase_r[31:30] + {1'b0, phase_r[29]};
        cnt_nxt       = '0;
        state_nxt     = S_ROT;
      end
      S_ROT: begin
        cor_ctrl.step = 1'b1;
        cnt_nxt       = cnt_r + ITER_W'(1);
        if (cnt_r == K_LAST) begin
          state_nxt = S_SINCOS;
        end
      end
      S_SINCOS: begin
        case (quad_r)
          QUAD_0: begin
            cs_nxt = xs;
            sn_nxt = ys;
          end
          QUAD_1: begin
            cs_nxt = -ys;
            sn_nxt = xs;
          end
          QUAD_2: begin
            cs_nxt = -xs;
            sn_nxt = -ys;
          end
          default: begin
            cs_nxt = ys;
            sn_nxt = -xs;
          end
        endcase
        cnt_nxt   = '0;
        state_nxt = S_MIX;
      end
      S_MIX: begin
        cnt_nxt = cnt_r + ITER_W'(1);
        case (cnt_r)
          STEP0: begin
            mul_a = MUL_AW'(si_r);
            mul_b = MUL_BW'(sn_r);
          end
          STEP1: begin
            mul_a  = MUL_AW'(sq_r);
            mul_b  = MUL_BW'(cs_r);
            re_nxt = p_mix;
          end
          STEP2: begin
            mul_a  = MUL_AW'(si_r);
            mul_b  = MUL_BW'(cs_r);
            re_nxt = re_r - p_mix;
          end
          STEP3: begin
            mul_a  = MUL_AW'(sq_r);
            mul_b  = MUL_BW'(sn_r);
            im_nxt = p_mix;
          end
          default: begin
            im_nxt    = im_r + p_mix;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        // hold here while the previous result is still waiting
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = out_val;
          xr_nxt        = sat_lp((LP_W+3)'(rs_re));
          xi_nxt        = sat_lp((LP_W+3)'(rs_im));
          cnt_nxt       = '0;
          state_nxt     = S_LPF;
        end
      end
      S_LPF: begin
        cnt_nxt = cnt_r + ITER_W'(1);
        case (cnt_r)
          STEP0: begin
            dr_nxt = (LP_W+1)'(xr_r) - (LP_W+1)'(lpr_r);
            di_nxt = (LP_W+1)'(xi_r) - (LP_W+1)'(lpi_r);
          end
          STEP1: begin
            mul_a = MUL_AW'(signed'({1'b0, coeff_r}));
            mul_b = MUL_BW'(dr_r);
          end
          STEP2: begin
            mul_a      = MUL_AW'(signed'({1'b0, coeff_r}));
            mul_b      = MUL_BW'(di_r);
            lpstep_nxt = lp_sum[41:16];
          end
          STEP3: begin
            lpr_nxt    = sat_lp((LP_W+3)'(lpr_r) + (LP_W+3)'(lpstep_r));
            lpstep_nxt = lp_sum[41:16];
          end
          default: begin
            lpi_nxt   = sat_lp((LP_W+3)'(lpi_r) + (LP_W+3)'(lpstep_r));
            state_nxt = S_VSETUP;
          end
        endcase
      end
      S_VSETUP: begin
        cnt_nxt = '0;
        if (lpr_r == '0 && lpi_r == '0) begin
          err_nxt   = '0;
          state_nxt = S_CORR;
        end else if (lpr_r < 0) begin
          // vector in the left half plane: full quarter turn toward its side
          err_nxt   = (lpi_r >= 0) ? QUARTER_TURN : -QUARTER_TURN;
          state_nxt = S_CORR;
        end else begin
          cor_ctrl.load = 1'b1;
          cor_x0        = CW'(signed'({lpr_r, 8'b0}));
          cor_y0        = CW'(signed'({lpi_r, 8'b0}));
          cor_z0        = '0;
          state_nxt     = S_VEC;
        end
      end
      S_VEC: begin
        cor_ctrl.step = 1'b1;
        cor_ctrl.vec  = 1'b1;
        cnt_nxt       = cnt_r + ITER_W'(1);
        if (cnt_r == K_LAST) begin
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        err_nxt   = z_clamp;
        cnt_nxt   = '0;
        state_nxt = S_CORR;
      end
      S_CORR: begin
        cnt_nxt = cnt_r + ITER_W'(1);
        case (cnt_r)
          STEP0: begin
            mul_a = signed'({1'b0, pg_r});
            mul_b = MUL_BW'(err_r);
          end
          STEP1: begin
            mul_a    = signed'({1'b0, fg_r});
            mul_b    = MUL_BW'(err_r);
            corr_nxt = c_sum[63:32];
          end
          STEP2: begin
            phase_nxt = (phase_r + corr_r) & KEEP;
            corr_nxt  = c_sum[63:32];
          end
          default: begin
            inc_nxt   = (inc_r + corr_r) & KEEP;
            state_nxt = S_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_FILTER_COEFF: coeff_nxt = cfg_data[15:0];
        REG_START_FREQ: begin
          inc_nxt   = cfg_data & KEEP;
          phase_nxt = '0;
        end
        REG_PHASE_GAIN:   pg_nxt = cfg_data;
        REG_FREQ_GAIN:    fg_nxt = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      inc_r       <= START_FREQ_RST & KEEP;
      coeff_r     <= FILTER_COEFF_RST;
      pg_r        <= PHASE_GAIN_RST;
      fg_r        <= FREQ_GAIN_RST;
      lpr_r       <= '0;
      lpi_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      inc_r       <= inc_nxt;
      coeff_r     <= coeff_nxt;
      pg_r        <= pg_nxt;
      fg_r        <= fg_nxt;
      lpr_r       <= lpr_nxt;
      lpi_r       <= lpi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sq_r       <= sq_nxt;
    out_data_r <= out_data_nxt;
    quad_r     <= quad_nxt;
    sn_r       <= sn_nxt;
    cs_r       <= cs_nxt;
    re_r       <= re_nxt;
    im_r       <= im_nxt;
    xr_r       <= xr_nxt;
    xi_r       <= xi_nxt;
    dr_r       <= dr_nxt;
    di_r       <= di_nxt;
    lpstep_r   <= lpstep_nxt;
    err_r      <= err_nxt;
    corr_r     <= corr_nxt;
  end

  assign in_ready       = (state_r == S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_mixed_real = out_data_r;
  assign cfg_ready      = 1'b1;

endmodule

>>> sv/pfpll_checker.sv
// port-level checks of the pilot loop, bound to the top level
`include "pilot_frequency_phase_lock_loop_assert.svh"

module pfpll_checker #(
  parameter int SAMPLE_WIDTH = pfpll_pkg::SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] out_mixed_real
);

  logic       in_xfer, out_xfer;
  logic [1:0] pend_r, pend_nxt;

  assign in_xfer  = in_valid & in_ready;
  assign out_xfer = out_valid & out_ready;

  // items taken in but whose result has not left yet
  always_comb begin
    pend_nxt = pend_r;
    if (in_xfer && !out_xfer) begin
      pend_nxt = pend_r + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pend_nxt = pend_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `PFPLL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_mixed_real))
  `PFPLL_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_xfer, !in_ready)
  `PFPLL_ASSERT_IMPL(a_no_spurious_out, clk, rst_n, out_valid, pend_r != 2'd0)
  `PFPLL_ASSERT_IMPL(a_pending_bound, clk, rst_n, in_xfer, pend_r == 2'd0 || pend_r == 2'd1)

endmodule

bind pilot_frequency_phase_lock_loop pfpll_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_pfpll_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_mixed_real (out_mixed_real)
);
